// File: rtl/core/pdca_pkg.sv
// Shared types and constants of the clamped PI drive controller.
// Used by the configuration registers, the control law and the top level.
// Depends on nothing.
package pdca_pkg;

  // Fraction bits kept in the drive accumulator; legal range 12 to 24.
  localparam int DRIVE_FRACTION_BITS = 20;
  // A Q8.8 by Q4.12 product carries 20 fraction bits.
  localparam int PRODUCT_FRAC = 20;
  localparam int DRIVE_MAX    = 100;
  localparam int DRIVE_START  = 72;

  // Shifts that bring a product to the accumulator scale.
  localparam int RSH = (DRIVE_FRACTION_BITS <= PRODUCT_FRAC) ?
                       (PRODUCT_FRAC - DRIVE_FRACTION_BITS) : 0;
  localparam int LSH = (DRIVE_FRACTION_BITS > PRODUCT_FRAC) ?
                       (DRIVE_FRACTION_BITS - PRODUCT_FRAC) : 0;

  // Accumulator width: just enough for 100 << DRIVE_FRACTION_BITS.
  localparam int ACC_W = $clog2((longint'(DRIVE_MAX) << DRIVE_FRACTION_BITS) + 1);
  // Width of the signed sum of accumulator and both terms.
  localparam int SUM_W = 49 + LSH + 4;

  localparam logic [ACC_W-1:0] DRIVE_TOP   = ACC_W'(DRIVE_MAX) << DRIVE_FRACTION_BITS;
  localparam logic [ACC_W-1:0] DRIVE_RESET = ACC_W'(DRIVE_START) << DRIVE_FRACTION_BITS;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_SETPOINT = 2'd0,
    REG_GAIN_P   = 2'd1,
    REG_GAIN_I   = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  localparam logic signed [15:0] SETPOINT_RESET = 16'sd0;
  localparam logic [15:0]        GAIN_P_RESET   = 16'd41;
  localparam logic [15:0]        GAIN_I_RESET   = 16'd41;

  // Register values handed to the control law.
  typedef struct packed {
    logic signed [15:0] setpoint;
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic [6:0]         drive;
    logic signed [16:0] deviation;
    logic               clamped;
  } res_t;

endpackage

// File: rtl/core/pdca_cfg.sv
// Configuration registers of the PI drive controller behind an APB-style port.
// Depends on pdca_pkg for the register map and the cfg_t bundle.
module pdca_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pdca_pkg::ADDR_W-1:0]  paddr,
  input  logic [pdca_pkg::DATA_W-1:0]  pwdata,
  output logic [pdca_pkg::DATA_W-1:0]  prdata,
  output pdca_pkg::cfg_t               cfg
);

  logic signed [15:0] setpoint_r;
  logic [15:0]        gain_p_r;
  logic [15:0]        gain_i_r;
  logic               wr_en;
  pdca_pkg::reg_idx_t idx;

  // Word index from the byte address.
  assign idx   = pdca_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  // Register writes; an index beyond the map is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= pdca_pkg::SETPOINT_RESET;
      gain_p_r   <= pdca_pkg::GAIN_P_RESET;
      gain_i_r   <= pdca_pkg::GAIN_I_RESET;
    end else if (wr_en) begin
      case (idx)
        pdca_pkg::REG_SETPOINT: setpoint_r <= pwdata[15:0];
        pdca_pkg::REG_GAIN_P:   gain_p_r   <= pwdata[15:0];
        pdca_pkg::REG_GAIN_I:   gain_i_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back; the setpoint is returned sign-extended.
  always_comb begin
    case (idx)
      pdca_pkg::REG_SETPOINT: prdata = {{16{setpoint_r[15]}}, setpoint_r};
      pdca_pkg::REG_GAIN_P:   prdata = {16'd0, gain_p_r};
      pdca_pkg::REG_GAIN_I:   prdata = {16'd0, gain_i_r};
      default:                prdata = '0;
    endcase
  end

  assign cfg.setpoint = setpoint_r;
  assign cfg.gain_p   = gain_p_r;
  assign cfg.gain_i   = gain_i_r;

endmodule

// File: rtl/core/pdca_law.sv
// PI control law with clamped drive and anti-windup: holds the drive
// accumulator and the integral, and forms one result from a pitch sample.
// Depends on pdca_pkg.
module pdca_law (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic signed [15:0]    pitch,
  input  pdca_pkg::cfg_t        cfg,
  output pdca_pkg::res_t        res
);

  localparam int SUM_W = pdca_pkg::SUM_W;
  localparam int ACC_W = pdca_pkg::ACC_W;

  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [31:0]     es_r, es_nxt;

  logic signed [16:0]     dev;
  logic signed [16:0]     gp_s, gi_s;
  logic signed [31:0]     es_add, es_back;
  logic signed [33:0]     p_prod;
  logic signed [48:0]     i_prod;
  logic signed [SUM_W-1:0] p_term, i_term, acc_sum;
  logic                   over, under, clip;

  // Add a 17-bit value to the integral, saturating at 32-bit signed.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [16:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {{16{b[16]}}, b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // Deviation and the integral after this sample.
  assign dev    = {pitch[15], pitch} - {cfg.setpoint[15], cfg.setpoint};
  assign es_add = sat_add(es_r, dev);

  // Both terms: products in Q.20, brought to the accumulator scale.
  assign gp_s   = {1'b0, cfg.gain_p};
  assign gi_s   = {1'b0, cfg.gain_i};
  assign p_prod = dev * gp_s;
  assign i_prod = es_add * gi_s;
  assign p_term = (SUM_W'(p_prod) >>> pdca_pkg::RSH) <<< pdca_pkg::LSH;
  assign i_term = (SUM_W'(i_prod) >>> pdca_pkg::RSH) <<< pdca_pkg::LSH;
  assign acc_sum = $signed({{(SUM_W-ACC_W){1'b0}}, acc_r}) + p_term + i_term;

  // Clamp to 0..100; on a clamp the deviation is taken back out.
  assign over    = acc_sum > $signed({{(SUM_W-ACC_W){1'b0}}, pdca_pkg::DRIVE_TOP});
  assign under   = acc_sum[SUM_W-1];
  assign clip    = over || under;
  assign es_back = sat_add(es_add, -dev);

  always_comb begin
    if (over) begin
      acc_nxt = pdca_pkg::DRIVE_TOP;
    end else if (under) begin
      acc_nxt = '0;
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
    es_nxt = clip ? es_back : es_add;
  end

  // State advances once per accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= pdca_pkg::DRIVE_RESET;
      es_r  <= '0;
    end else if (step) begin
      acc_r <= acc_nxt;
      es_r  <= es_nxt;
    end
  end

  assign res.drive     = 7'(acc_nxt >> pdca_pkg::DRIVE_FRACTION_BITS);
  assign res.deviation = dev;
  assign res.clamped   = clip;

`ifndef SYNTH
  // The accumulator never leaves the drive range.
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= pdca_pkg::DRIVE_TOP)
    else $error("drive accumulator above its top");

  // A clamped step leaves the accumulator at one of the bounds.
  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step && clip |=> (acc_r == '0) || (acc_r == pdca_pkg::DRIVE_TOP))
    else $error("clamped step left accumulator off its bounds");

  // Without a sample the state holds.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(acc_r) && $stable(es_r))
    else $error("controller state moved without a sample");
`endif

endmodule

// File: rtl/core/pi_drive_controller_antiwindup.sv
//  channel | direction | beat contents (lowest bits first)
//  in_     | slave     | tdata[15:0] pitch (Q8.8)
//  out_    | master    | tdata[6:0] drive, tdata[23:7] deviation; tuser clamped
//  cfg_    | APB       | 0x0 setpoint, 0x4 gain_p, 0x8 gain_i
//
// One beat is taken every cycle while the output is not stalled; each beat passes the
// input register and then the result register, where its result is offered.
// The rate is set by the state loop: integral update, gain multiply, accumulate
// and clamp all complete between the input register and the result register.
// Reset (synchronous, rst_n low) sets drive to 72 and the integral to 0.
// A stalled output holds its beat and back-pressures the input register.
// Depends on pdca_pkg, pdca_cfg and pdca_law.
module pi_drive_controller_antiwindup (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [15:0]                  in_tdata,   // [15:0] pitch
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [23:0]                  out_tdata,  // [6:0] drive, [23:7] deviation
  output logic                         out_tuser,  // [0] clamped
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pdca_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [pdca_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [pdca_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  pdca_pkg::cfg_t     cfg;
  pdca_pkg::res_t     res;
  pdca_pkg::res_t     res_r;
  logic               in_vld_r, out_vld_r;
  logic signed [15:0] pitch_r;
  logic               step;

  assign cfg_pready = 1'b1;

  pdca_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // A sample moves on when the result register is free or being emptied.
  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pitch_r <= in_tdata;
    end
  end

  pdca_law u_law (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .pitch (pitch_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {res_r.deviation, res_r.drive};
  assign out_tuser  = res_r.clamped;

endmodule

// File: verif/pdca_drive_checker.sv
// Checker for the clamped PI drive controller: watches the input, result and register
// channels, predicts every result beat and compares it field by field.
// Depends on pdca_pkg for the register indexes, the result layout and the fraction width.
module pdca_drive_checker
  import pdca_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       in_tdata,   // [15:0] pitch
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [23:0]       out_tdata,  // [6:0] drive, [23:7] deviation
  input  logic              out_tuser,  // [0] clamped
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // A Q8.8 by Q4.12 product has 20 fraction bits; at most one of the two shifts is non-zero.
  localparam int     FB        = DRIVE_FRACTION_BITS;
  localparam int     Q_PRODUCT = 20;
  localparam int     DOWN      = (FB <= Q_PRODUCT) ? Q_PRODUCT - FB : 0;
  localparam int     UP        = (FB > Q_PRODUCT) ? FB - Q_PRODUCT : 0;
  localparam longint CEILING   = longint'(100) << FB;
  localparam longint START     = longint'(72) << FB;
  localparam longint I32_MAX   = 64'sd2147483647;
  localparam longint I32_MIN   = -64'sd2147483648;

  // Shadow of the registers and of the control state.
  logic signed [15:0] setpoint_q;
  logic [15:0]        kp_q;
  logic [15:0]        ki_q;
  longint             drive_acc;
  int                 integral;
  res_t               awaited[$];

  function automatic int add_sat32(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > I32_MAX) return int'(I32_MAX);
    if (s < I32_MIN) return int'(I32_MIN);
    return int'(s);
  endfunction

  // Arithmetic shift of a negative product rounds towards minus infinity.
  function automatic longint to_accum_scale(input longint prod);
    return (prod >>> DOWN) <<< UP;
  endfunction

  // One control tick: integral, both terms, clamp and anti-windup.
  function automatic res_t step_control_law(input logic signed [15:0] pitch);
    longint dev;
    longint acc;
    logic   clip;
    res_t   r;
    dev      = longint'(pitch) - longint'(setpoint_q);
    integral = add_sat32(integral, dev);
    acc = drive_acc + to_accum_scale(dev * longint'(kp_q))
        + to_accum_scale(longint'(integral) * longint'(ki_q));
    clip = 1'b0;
    if (acc > CEILING) begin
      acc  = CEILING;
      clip = 1'b1;
    end else if (acc < 0) begin
      acc  = 0;
      clip = 1'b1;
    end
    // A clamped tick takes its own deviation back out of the integral.
    if (clip) integral = add_sat32(integral, -dev);
    drive_acc   = acc;
    r.drive     = 7'(acc >>> FB);
    r.deviation = 17'(dev);
    r.clamped   = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    logic signed [16:0] got_dev;
    if (!rst_n) begin
      setpoint_q = SETPOINT_RESET;
      kp_q       = GAIN_P_RESET;
      ki_q       = GAIN_I_RESET;
      drive_acc  = START;
      integral   = 0;
      awaited.delete();
    end else begin
      // Result beats are matched first; they always stem from earlier input beats.
      if (out_tvalid && out_tready) begin
        got_dev = $signed(out_tdata[23:7]);
        if (awaited.size() == 0) begin
          $error("result beat with no input outstanding: drive %0d, deviation %0d",
                 out_tdata[6:0], got_dev);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (out_tdata[6:0] !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, out_tdata[6:0]);
            fail_count++;
          end
          if (got_dev !== want.deviation) begin
            $error("deviation: expected %0d, got %0d", want.deviation, got_dev);
            fail_count++;
          end
          if (out_tuser !== want.clamped) begin
            $error("clamped: expected %0b, got %0b", want.clamped, out_tuser);
            fail_count++;
          end
        end
      end

      // Register writes land in the shadow copy; the unused index is ignored.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_SETPOINT: setpoint_q = cfg_pwdata[15:0];
          REG_GAIN_P:   kp_q       = cfg_pwdata[15:0];
          REG_GAIN_I:   ki_q       = cfg_pwdata[15:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) awaited.push_back(step_control_law(in_tdata));
    end
    pending = awaited.size();
  end

endmodule

// File: verif/tb_pi_drive_controller_antiwindup.sv
// Top of the drive controller testbench: clock, reset, pitch and register stimulus,
// receiver stalls and the final verdict. Checking is done by pdca_drive_checker.
// Depends on pdca_pkg, pdca_drive_checker and the pi_drive_controller_antiwindup RTL.
module tb_pi_drive_controller_antiwindup;
  timeunit 1ns;
  timeprecision 1ps;
  import pdca_pkg::*;

  localparam int HOLD_CYCLES = 64;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;   // [15:0] pitch
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;  // [6:0] drive, [23:7] deviation
  logic              out_tuser;  // [0] clamped
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;
  int                fail_count;
  int                pending;

  // Stimulus state; calm and the hold counts are shared with the receiver.
  bit                 calm;
  int                 hold_req;
  int                 hold_served;
  logic signed [15:0] cur_sp;

  pi_drive_controller_antiwindup u_top (.*);

  pdca_drive_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("pi_drive_controller_antiwindup test failed");
    $finish;
  end

  // Receiver: random stalls, a calm stretch, and long hold-offs on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served < hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_served++;
      end else begin
        out_tready = calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Offers one pitch beat, sometimes after idle cycles, and waits for acceptance.
  task automatic send_pitch(input logic signed [15:0] p);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = p;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering beats and waits until every result has come back.
  task automatic quiesce();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Setup and access cycle; the upper data bits carry noise the block must ignore.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = ADDR_W'(idx) << 2;
    cfg_pwdata  = DATA_W'({16'($urandom), val});
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic configure(input logic signed [15:0] sp, input logic [15:0] kp,
                           input logic [15:0] ki);
    quiesce();
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_NONE, 16'($urandom));
    cur_sp = sp;
  endtask

  // Mostly pitches close to the setpoint, now and then anything at all.
  function automatic logic signed [15:0] pick_pitch();
    longint p;
    int     off;
    if ($urandom_range(0, 99) < 80) begin
      off = int'($urandom_range(0, 4096)) - 2048;
      p   = longint'(cur_sp) + off;
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return 16'(p);
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_gain(input int modest_top);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 16'd0;
    if (roll < 20) return 16'hFFFF;
    if (roll < 40) return 16'($urandom);
    return 16'($urandom_range(0, modest_top));
  endfunction

  function automatic logic signed [15:0] pick_setpoint();
    if ($urandom_range(0, 99) < 30) return 16'($urandom);
    return 16'(int'($urandom_range(0, 2048)) - 1024);
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    calm        = 1'b0;
    hold_req    = 0;
    hold_served = 0;
    cur_sp      = SETPOINT_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset register values with the pitch extremes.
    send_pitch(16'sd0);
    send_pitch(16'sd32767);
    send_pitch(-16'sd32768);

    // Unit proportional gain: clamp high, sit exactly on both bounds, then clamp low.
    configure(16'sd0, 16'd4096, 16'd0);
    send_pitch(16'sd32767);
    send_pitch(16'sd0);
    send_pitch(-16'sd25600);
    send_pitch(-16'sd1);
    send_pitch(-16'sd32768);
    send_pitch(16'sd256);

    // Largest deviations of either sign with full gains.
    configure(-16'sd32768, 16'hFFFF, 16'hFFFF);
    send_pitch(16'sd32767);
    send_pitch(-16'sd32768);
    configure(16'sd32767, 16'hFFFF, 16'hFFFF);
    send_pitch(-16'sd32768);
    send_pitch(16'sd32767);

    // Zero gains leave the drive where it is.
    configure(pick_setpoint(), 16'd0, 16'd0);
    send_pitch(16'($urandom));
    send_pitch(16'($urandom));

    // Random operation, reconfigured every hundred beats.
    for (int n = 0; n < 1050; n++) begin
      if (n % 100 == 0) configure(pick_setpoint(), pick_gain(800), pick_gain(60));
      if (n == 350 || n == 950) hold_req++;
      calm = (n >= 450 && n < 700);
      send_pitch(pick_pitch());
    end
    calm = 1'b0;

    // Push the integral well up with the loop gains off, then run the loop from there.
    configure(-16'sd32768, 16'd0, 16'd0);
    for (int n = 0; n < 20; n++) send_pitch(16'sd32767);
    configure(pick_setpoint(), pick_gain(800), 16'($urandom_range(1, 60)));
    for (int n = 0; n < 15; n++) send_pitch(pick_pitch());

    // Then well down the other way.
    configure(16'sd32767, 16'd0, 16'd0);
    for (int n = 0; n < 40; n++) send_pitch(-16'sd32768);
    configure(pick_setpoint(), pick_gain(800), 16'($urandom_range(1, 60)));
    for (int n = 0; n < 15; n++) send_pitch(pick_pitch());

    // Drain with a bound, then let the pipeline settle.
    @(negedge clk);
    in_tvalid = 1'b0;
    for (int w = 0; w < 2000 && pending != 0; w++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (pending != 0) $error("%0d result beats never arrived", pending);

    if (fail_count == 0 && pending == 0) begin
      $display("pi_drive_controller_antiwindup test passed");
    end else begin
      $display("pi_drive_controller_antiwindup test failed");
    end
    $finish;
  end

endmodule

// File: pi_drive_controller_antiwindup.f
rtl/core/pdca_pkg.sv
rtl/core/pdca_cfg.sv
rtl/core/pdca_law.sv
rtl/core/pi_drive_controller_antiwindup.sv
verif/pdca_drive_checker.sv
verif/tb_pi_drive_controller_antiwindup.sv
